// ----- sv/coap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_pkg
// types and constants shared by the coap message parser files
// ----------------------------------------------------------------------------
package coap_pkg;

  typedef enum logic [2:0] {
    PH_HEADER  = 3'd0,
    PH_TOKEN   = 3'd1,
    PH_OPTHEAD = 3'd2,
    PH_EXT     = 3'd3,
    PH_VALUE   = 3'd4,
    PH_PAYLOAD = 3'd5,
    PH_DISCARD = 3'd6
  } phase_t;

  typedef enum logic [2:0] {
    KIND_HEADER   = 3'd0,
    KIND_TOKEN    = 3'd1,
    KIND_OPT_PART = 3'd2,
    KIND_OPT_DONE = 3'd3,
    KIND_OPT_VAL  = 3'd4,
    KIND_MARKER   = 3'd5,
    KIND_PAYLOAD  = 3'd6,
    KIND_DISCARD  = 3'd7
  } kind_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_SHORT   = 2'd1,
    ST_FORMAT  = 2'd2,
    ST_VERSION = 2'd3
  } status_t;

  // extension step codes
  localparam logic [1:0] EXT_NONE = 2'd0;
  localparam logic [1:0] EXT_ONE  = 2'd1;
  localparam logic [1:0] EXT_HI   = 2'd2;
  localparam logic [1:0] EXT_LO   = 2'd3;

  localparam logic [7:0]  MARKER_BYTE = 8'hFF;
  localparam logic [3:0]  NIB_EXT8    = 4'd13;
  localparam logic [3:0]  NIB_EXT16   = 4'd14;
  localparam logic [3:0]  NIB_BAD     = 4'd15;
  localparam logic [3:0]  MAX_TKL     = 4'd8;
  localparam logic [15:0] EXT8_BIAS   = 16'd13;
  localparam logic [15:0] EXT16_BIAS  = 16'd269;
  localparam logic [1:0]  COAP_VER    = 2'd1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  byte_kind;
    logic [7:0]  data_out;
    logic [15:0] opt_num;
    logic [15:0] option_length;
    logic [1:0]  mtype;
    logic [3:0]  token_length;
    logic [2:0]  code_cls;
    logic [4:0]  code_sub;
    logic [15:0] msg_id;
    logic        msg_done;
    logic [1:0]  status;
    logic        has_payload;
  } out_item_t;

  function automatic logic [1:0] nibble_ext(input logic [3:0] n);
    nibble_ext = (n == NIB_EXT8) ? EXT_ONE : ((n == NIB_EXT16) ? EXT_HI : EXT_NONE);
  endfunction

endpackage

// ----- sv/coap_core.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_core
// per-byte parse state and classification, one byte per cycle while step is high
// ----------------------------------------------------------------------------
module coap_core import coap_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      step,
  input  in_item_t  item,
  input  logic      short_fmt,
  output out_item_t res
);

  phase_t      phase_r, phase_nxt;
  logic [1:0]  hcnt_r, hcnt_nxt;
  logic [1:0]  ver_r, ver_nxt;
  logic [1:0]  type_r, type_nxt;
  logic [3:0]  tkl_r, tkl_nxt;
  logic [7:0]  code_r, code_nxt;
  logic [15:0] id_r, id_nxt;
  logic [15:0] left_r, left_nxt;
  logic [15:0] prev_r, prev_nxt;
  logic [15:0] dacc_r, dacc_nxt;
  logic [15:0] lacc_r, lacc_nxt;
  logic [1:0]  dp_r, dp_nxt;
  logic [1:0]  lp_r, lp_nxt;
  logic [1:0]  err_r, err_nxt;
  logic        pay_r, pay_nxt;

  kind_t       kind;
  logic [7:0]  b;
  logic [3:0]  dn, ln;
  logic [15:0] left_dec;
  logic [15:0] ext_val;
  logic [1:0]  ext_code, ext_next;
  logic        fin;
  logic [1:0]  status;

  assign b        = item.data_byte;
  assign dn       = b[7:4];
  assign ln       = b[3:0];
  assign left_dec = left_r - 16'd1;
  assign ext_code = (dp_r != EXT_NONE) ? dp_r : lp_r;

  // shared extension step for delta or length
  always_comb begin
    ext_val  = (dp_r != EXT_NONE) ? dacc_r : lacc_r;
    ext_next = EXT_NONE;
    unique case (ext_code)
      EXT_ONE: ext_val = {8'd0, b} + EXT8_BIAS;
      EXT_HI: begin
        ext_val  = {b, 8'd0};
        ext_next = EXT_LO;
      end
      EXT_LO:   ext_val = (ext_val | {8'd0, b}) + EXT16_BIAS;
      EXT_NONE: ext_val = ext_val;
      default:  ext_val = ext_val;
    endcase
  end

  always_comb begin
    phase_nxt = phase_r;
    hcnt_nxt  = hcnt_r;
    ver_nxt   = ver_r;
    type_nxt  = type_r;
    tkl_nxt   = tkl_r;
    code_nxt  = code_r;
    id_nxt    = id_r;
    left_nxt  = left_r;
    prev_nxt  = prev_r;
    dacc_nxt  = dacc_r;
    lacc_nxt  = lacc_r;
    dp_nxt    = dp_r;
    lp_nxt    = lp_r;
    err_nxt   = err_r;
    pay_nxt   = pay_r;
    kind      = KIND_DISCARD;
    fin       = 1'b0;
    unique case (phase_r)
      PH_HEADER: begin
        kind = KIND_HEADER;
        unique case (hcnt_r)
          2'd0: begin
            ver_nxt  = b[7:6];
            type_nxt = b[5:4];
            tkl_nxt  = b[3:0];
          end
          2'd1: code_nxt = b;
          2'd2: id_nxt = {b, 8'd0};
          2'd3: begin
            id_nxt = id_r | {8'd0, b};
            if (ver_r != COAP_VER) begin
              err_nxt   = ST_VERSION;
              phase_nxt = PH_DISCARD;
            end else if (tkl_r > MAX_TKL) begin
              err_nxt   = ST_FORMAT;
              phase_nxt = PH_DISCARD;
            end else begin
              left_nxt  = {12'd0, tkl_r};
              phase_nxt = (tkl_r != 4'd0) ? PH_TOKEN : PH_OPTHEAD;
            end
          end
          default: ;
        endcase
        if (hcnt_r != 2'd3) hcnt_nxt = hcnt_r + 2'd1;
      end
      PH_TOKEN, PH_VALUE: begin
        kind     = (phase_r == PH_TOKEN) ? KIND_TOKEN : KIND_OPT_VAL;
        left_nxt = left_dec;
        if (left_dec == 16'd0) phase_nxt = PH_OPTHEAD;
      end
      PH_OPTHEAD: begin
        if (b == MARKER_BYTE) begin
          kind      = KIND_MARKER;
          phase_nxt = PH_PAYLOAD;
        end else if (dn == NIB_BAD || ln == NIB_BAD) begin
          kind      = KIND_DISCARD;
          err_nxt   = ST_FORMAT;
          phase_nxt = PH_DISCARD;
        end else begin
          dacc_nxt = {12'd0, dn};
          lacc_nxt = {12'd0, ln};
          dp_nxt   = nibble_ext(dn);
          lp_nxt   = nibble_ext(ln);
          if (dp_nxt == EXT_NONE && lp_nxt == EXT_NONE) begin
            fin = 1'b1;
          end else begin
            kind      = KIND_OPT_PART;
            phase_nxt = PH_EXT;
          end
        end
      end
      PH_EXT: begin
        if (dp_r != EXT_NONE) begin
          dacc_nxt = ext_val;
          dp_nxt   = ext_next;
        end else begin
          lacc_nxt = ext_val;
          lp_nxt   = ext_next;
        end
        if (dp_nxt == EXT_NONE && lp_nxt == EXT_NONE) fin = 1'b1;
        else kind = KIND_OPT_PART;
      end
      PH_PAYLOAD: begin
        kind    = KIND_PAYLOAD;
        pay_nxt = 1'b1;
      end
      PH_DISCARD: kind = KIND_DISCARD;
      default:    kind = KIND_DISCARD;
    endcase
    // option head complete
    if (fin) begin
      kind      = KIND_OPT_DONE;
      prev_nxt  = prev_r + dacc_nxt;
      left_nxt  = lacc_nxt;
      phase_nxt = (lacc_nxt != 16'd0) ? PH_VALUE : PH_OPTHEAD;
    end
  end

  always_comb begin
    status = err_nxt;
    if (item.last_byte && err_nxt == ST_OK &&
        (phase_nxt == PH_HEADER || phase_nxt == PH_TOKEN ||
         phase_nxt == PH_EXT || phase_nxt == PH_VALUE))
      status = short_fmt ? ST_FORMAT : ST_SHORT;
    res.byte_kind     = kind;
    res.data_out      = b;
    res.opt_num       = (kind == KIND_OPT_PART) ? 16'd0 : prev_nxt;
    res.option_length = (kind == KIND_OPT_PART) ? 16'd0 : lacc_nxt;
    res.mtype         = type_nxt;
    res.token_length  = tkl_nxt;
    res.code_cls      = code_nxt[7:5];
    res.code_sub      = code_nxt[4:0];
    res.msg_id        = id_nxt;
    res.msg_done      = item.last_byte;
    res.status        = status;
    res.has_payload   = pay_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n || (step && item.last_byte)) begin
      phase_r <= PH_HEADER;
      hcnt_r  <= 2'd0;
      ver_r   <= 2'd0;
      type_r  <= 2'd0;
      tkl_r   <= 4'd0;
      code_r  <= 8'd0;
      id_r    <= 16'd0;
      left_r  <= 16'd0;
      prev_r  <= 16'd0;
      dacc_r  <= 16'd0;
      lacc_r  <= 16'd0;
      dp_r    <= EXT_NONE;
      lp_r    <= EXT_NONE;
      err_r   <= ST_OK;
      pay_r   <= 1'b0;
    end else if (step) begin
      phase_r <= phase_nxt;
      hcnt_r  <= hcnt_nxt;
      ver_r   <= ver_nxt;
      type_r  <= type_nxt;
      tkl_r   <= tkl_nxt;
      code_r  <= code_nxt;
      id_r    <= id_nxt;
      left_r  <= left_nxt;
      prev_r  <= prev_nxt;
      dacc_r  <= dacc_nxt;
      lacc_r  <= lacc_nxt;
      dp_r    <= dp_nxt;
      lp_r    <= lp_nxt;
      err_r   <= err_nxt;
      pay_r   <= pay_nxt;
    end
  end

endmodule

// ----- sv/coap_message_parser.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_message_parser
// classifies each datagram byte and decodes header, token and options
// ----------------------------------------------------------------------------
//  channel | direction | handshake     | payload
//  in_     | input     | valid / stall | in_item_t
//  out_    | output    | valid / stall | out_item_t
//  cfg_    | input     | valid / ready | short_is_format_error
//
// one byte per cycle while out_stall is low, one result per byte; each byte passes the input
// register, parse logic and result register. the input register and a one-entry skid
// buffer take a new request every cycle while out_stall is low.
// rst_n is synchronous; after reset the parse state is at the header and
// short_is_format_error is 1. cfg_ready is always high.
module coap_message_parser import coap_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_data,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_data,
  input  logic      cfg_valid,
  output logic      cfg_ready,
  input  logic      cfg_data
);

  logic      cfg_r;
  logic      iv_r;
  in_item_t  item_r;
  logic      sk_v_r;
  in_item_t  sk_r;
  logic      ov_r;
  out_item_t od_r;
  logic      step;
  out_item_t res;
  logic      acc;

  assign cfg_ready = 1'b1;
  assign in_stall  = sk_v_r;
  assign acc       = in_valid && !in_stall;
  // input register advances into the result register when it is free
  assign step      = iv_r && (!ov_r || !out_stall);

  coap_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (step),
    .item      (item_r),
    .short_fmt (cfg_r),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= 1'b1;
    end else if (cfg_valid) begin
      cfg_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      iv_r   <= 1'b0;
      sk_v_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      if (step || !ov_r || !out_stall) ov_r <= step ? 1'b1 : (ov_r && out_stall);
      if (!iv_r || step) begin
        iv_r   <= sk_v_r || acc;
        sk_v_r <= 1'b0;
      end else if (acc) begin
        sk_v_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) od_r <= res;
    if (!iv_r || step) item_r <= sk_v_r ? sk_r : in_data;
    if (acc && iv_r && !step) sk_r <= in_data;
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;

endmodule

// ----- sv/coap_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// coap_checker
// port-level checks on the parser result stream
// ----------------------------------------------------------------------------
module coap_checker import coap_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_valid,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_item_t out_data
);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  a_pass: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_kind == KIND_OPT_PART |->
      out_data.opt_num == 16'd0 && out_data.option_length == 16'd0)
    else $error("partial option head shows option fields");

  // input stall only rises after a request was taken
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(in_stall) |-> $past(in_valid && !in_stall))
    else $error("input stall without a request");

  a_first: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.byte_kind == KIND_DISCARD && out_data.msg_done |->
      out_data.status != ST_OK)
    else $error("discarded final byte with ok status");

  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind coap_message_parser coap_checker u_coap_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
